@@ rtl/tslf_pkg.sv @@
package tslf_pkg;

    localparam int POS_W       = 32;
    localparam int SPEED_W     = 24;
    localparam int LAG_W       = 31;
    localparam int TSTEP_W     = 16;
    localparam int FRAC_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PROD_W      = SPEED_W + TSTEP_W;

    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SPEED_X       = 3'd0,
        REG_SPEED_Y       = 3'd1,
        REG_MAX_LAG_X     = 3'd2,
        REG_MAX_LAG_Y     = 3'd3,
        REG_WINDOW_LEFT   = 3'd4,
        REG_WINDOW_TOP    = 3'd5,
        REG_WINDOW_RIGHT  = 3'd6,
        REG_WINDOW_BOTTOM = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic                      has_target;
        logic signed [POS_W-1:0]   follow_x;
        logic signed [POS_W-1:0]   follow_y;
        logic        [TSTEP_W-1:0] time_step;
    } in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } out_t;

    typedef struct packed {
        logic        [SPEED_W-1:0] speed_x;
        logic        [SPEED_W-1:0] speed_y;
        logic        [LAG_W-1:0]   max_lag_x;
        logic        [LAG_W-1:0]   max_lag_y;
        logic signed [POS_W-1:0]   window_left;
        logic signed [POS_W-1:0]   window_top;
        logic signed [POS_W-1:0]   window_right;
        logic signed [POS_W-1:0]   window_bottom;
    } cfg_t;

    // one axis, classified and with its cam-independent arithmetic done
    typedef struct packed {
        logic                    snap;
        logic                    lag_on;
        logic signed [POS_W-1:0] pt;
        logic        [LAG_W-1:0] lag;
        logic signed [POS_W-1:0] lag_lo;
        logic signed [POS_W-1:0] lag_hi;
        logic        [POS_W-1:0] step;
    } axis_cmd_t;

    typedef struct packed {
        logic      has_target;
        axis_cmd_t x;
        axis_cmd_t y;
    } cmd_t;

endpackage

@@ rtl/tslf_fifo.sv @@
module tslf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && full) |-> rd_en)
        else $error("write into full queue without read");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("read from empty queue");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count lost a write");

endmodule

@@ rtl/tslf_front.sv @@
module tslf_front (
    input  tslf_pkg::cfg_t cfg,
    input  tslf_pkg::in_t  item,
    output tslf_pkg::cmd_t cmd
);

    function automatic logic signed [tslf_pkg::POS_W-1:0] sat33(
        input logic signed [tslf_pkg::POS_W:0] v
    );
        logic signed [tslf_pkg::POS_W-1:0] r;
        if (v[tslf_pkg::POS_W] != v[tslf_pkg::POS_W-1])
        begin
            r = v[tslf_pkg::POS_W] ? tslf_pkg::POS_MIN : tslf_pkg::POS_MAX;
        end
        else
        begin
            r = v[tslf_pkg::POS_W-1:0];
        end
        return r;
    endfunction

    function automatic tslf_pkg::axis_cmd_t prep(
        input logic signed [tslf_pkg::POS_W-1:0]   pt,
        input logic        [tslf_pkg::SPEED_W-1:0] speed,
        input logic        [tslf_pkg::LAG_W-1:0]   lag,
        input logic        [tslf_pkg::TSTEP_W-1:0] tstep
    );
        tslf_pkg::axis_cmd_t c;
        logic signed [tslf_pkg::POS_W:0]  pt_e;
        logic signed [tslf_pkg::POS_W:0]  lag_e;
        logic        [tslf_pkg::PROD_W-1:0] prod;
        pt_e     = {pt[tslf_pkg::POS_W-1], pt};
        lag_e    = {2'b00, lag};
        prod     = speed * tstep;
        c.snap   = (speed == '0);
        c.lag_on = (lag != '0);
        c.pt     = pt;
        c.lag    = lag;
        c.lag_lo = sat33(pt_e - lag_e);
        c.lag_hi = sat33(pt_e + lag_e);
        // step size in Q24.8, truncated
        c.step   = prod[tslf_pkg::PROD_W-1:tslf_pkg::FRAC_W];
        return c;
    endfunction

    always_comb
    begin
        cmd.has_target = item.has_target;
        cmd.x = prep(item.follow_x, cfg.speed_x, cfg.max_lag_x, item.time_step);
        cmd.y = prep(item.follow_y, cfg.speed_y, cfg.max_lag_y, item.time_step);
    end

endmodule

@@ rtl/tslf_back.sv @@
module tslf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tslf_pkg::cfg_t      cfg,
    input  tslf_pkg::cmd_t      cmd,
    input  logic                cmd_valid,
    input  logic                out_space,
    output logic                cmd_take,
    output tslf_pkg::out_t      res
);

    // retire the head command once the result queue can hold its beat
    assign cmd_take = cmd_valid && out_space;

    tslf_back_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cmd    (cmd),
        .update (cmd_take),
        .res    (res)
    );

endmodule

@@ rtl/tslf_back_core.sv @@
module tslf_back_core (
    input  logic                clk,
    input  logic                rst_n,
    input  tslf_pkg::cfg_t      cfg,
    input  tslf_pkg::cmd_t      cmd,
    input  logic                update,
    output tslf_pkg::out_t      res
);

    localparam int W = tslf_pkg::POS_W;

    logic signed [W-1:0] cam_x_reg, cam_x_next;
    logic signed [W-1:0] cam_y_reg, cam_y_next;

    function automatic logic signed [W-1:0] follow(
        input logic signed [W-1:0] pos,
        input tslf_pkg::axis_cmd_t c
    );
        logic signed [W:0]   diff;
        logic        [W:0]   gap;
        logic                below;
        logic signed [W+1:0] moved;
        logic signed [W-1:0] r;
        diff  = {pos[W-1], pos} - {c.pt[W-1], c.pt};
        below = (pos < c.pt);
        gap   = below ? -diff : diff;
        moved = below ? {{2{pos[W-1]}}, pos} + {2'b00, c.step}
                      : {{2{pos[W-1]}}, pos} - {2'b00, c.step};
        priority if (c.snap)
        begin
            r = c.pt;
        end
        else if (c.lag_on && (gap > {2'b00, c.lag}))
        begin
            r = below ? c.lag_lo : c.lag_hi;
        end
        else if (pos != c.pt)
        begin
            r = ({1'b0, c.step} >= gap) ? c.pt : moved[W-1:0];
        end
        else
        begin
            r = pos;
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] clamp(
        input logic signed [W-1:0] pos,
        input logic signed [W-1:0] lo,
        input logic signed [W-1:0] hi
    );
        logic signed [W-1:0] r;
        r = (pos < lo) ? lo : pos;
        r = (r > hi) ? hi : r;
        return r;
    endfunction

    always_comb
    begin
        logic signed [W-1:0] fx;
        logic signed [W-1:0] fy;
        fx = cmd.has_target ? follow(cam_x_reg, cmd.x) : cam_x_reg;
        fy = cmd.has_target ? follow(cam_y_reg, cmd.y) : cam_y_reg;
        cam_x_next = clamp(fx, cfg.window_left, cfg.window_right);
        cam_y_next = clamp(fy, cfg.window_top, cfg.window_bottom);
    end

    assign res.pos_x = cam_x_next;
    assign res.pos_y = cam_y_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
        end
        else if (update)
        begin
            cam_x_reg <= cam_x_next;
            cam_y_reg <= cam_y_next;
        end
    end

endmodule

@@ rtl/two_axis_slew_limited_follower.sv @@
// two-axis slew-limited follower: each accepted beat carries a follow point,
// a Q8.8 time step and a has-target flag, and yields exactly one result beat
// with the new Q24.8 position. per axis: speed zero snaps to the point, a
// nonzero lag limit that is exceeded places the position at the point plus or
// minus the limit (saturated), otherwise the position steps toward the point
// by (speed * time_step) >> 8 without overshoot; then the window clamp applies
// (low edge first, high edge second, so an inverted window gives the high
// edge). without a target only the clamp applies. the block sustains one beat
// per cycle while the command queue has room; a taken beat goes into the
// command queue, and the back end retires its head into the result queue when
// that queue has room. the position update loop holds no register but the
// position, as the multiply and the lag saturation are done in the front end
// on the way into the command queue. the user must write the registers
// through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// speeds and lags reset to zero, the window to the full range (disabled).
module two_axis_slew_limited_follower #(
    parameter int MID_DEPTH = tslf_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = tslf_pkg::OUT_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input queue side
    input  logic                               push,
    output logic                               full,
    input  tslf_pkg::in_t                      item,
    // result queue side
    output logic                               empty,
    input  logic                               pop,
    output tslf_pkg::out_t                     result,
    // register write port
    input  logic                               cfg_we,
    input  logic [tslf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tslf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CMD_W = $bits(tslf_pkg::cmd_t);
    localparam int RES_W = $bits(tslf_pkg::out_t);

    tslf_pkg::cfg_t      cfg_reg;
    tslf_pkg::cmd_t      cmd_in;
    tslf_pkg::cmd_t      cmd_out;
    tslf_pkg::out_t      res;
    logic [CMD_W-1:0]    cmd_raw;
    logic [RES_W-1:0]    res_raw;
    logic                in_beat;
    logic                out_beat;
    logic                mid_empty;
    logic                out_full;
    logic                out_space;
    logic                cmd_take;

    // register file; the user must write it only while the block is idle, which it does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_x       <= '0;
            cfg_reg.speed_y       <= '0;
            cfg_reg.max_lag_x     <= '0;
            cfg_reg.max_lag_y     <= '0;
            cfg_reg.window_left   <= tslf_pkg::POS_MIN;
            cfg_reg.window_top    <= tslf_pkg::POS_MIN;
            cfg_reg.window_right  <= tslf_pkg::POS_MAX;
            cfg_reg.window_bottom <= tslf_pkg::POS_MAX;
        end
        else if (cfg_we)
        begin
            unique case (tslf_pkg::cfg_idx_t'(cfg_index))
                tslf_pkg::REG_SPEED_X:
                    cfg_reg.speed_x <= cfg_data[tslf_pkg::SPEED_W-1:0];
                tslf_pkg::REG_SPEED_Y:
                    cfg_reg.speed_y <= cfg_data[tslf_pkg::SPEED_W-1:0];
                tslf_pkg::REG_MAX_LAG_X:
                    cfg_reg.max_lag_x <= cfg_data[tslf_pkg::LAG_W-1:0];
                tslf_pkg::REG_MAX_LAG_Y:
                    cfg_reg.max_lag_y <= cfg_data[tslf_pkg::LAG_W-1:0];
                tslf_pkg::REG_WINDOW_LEFT:
                    cfg_reg.window_left <= cfg_data[tslf_pkg::POS_W-1:0];
                tslf_pkg::REG_WINDOW_TOP:
                    cfg_reg.window_top <= cfg_data[tslf_pkg::POS_W-1:0];
                tslf_pkg::REG_WINDOW_RIGHT:
                    cfg_reg.window_right <= cfg_data[tslf_pkg::POS_W-1:0];
                tslf_pkg::REG_WINDOW_BOTTOM:
                    cfg_reg.window_bottom <= cfg_data[tslf_pkg::POS_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input beat taken whenever the command queue has room
    assign in_beat  = push && !full;
    // result beat leaves the output queue
    assign out_beat = pop && !empty;

    // front end: classify the beat, do the multiply and lag saturation
    tslf_front u_front (
        .cfg  (cfg_reg),
        .item (item),
        .cmd  (cmd_in)
    );

    // command queue between front and back
    tslf_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (MID_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_beat),
        .wr_data (cmd_in),
        .rd_en   (cmd_take),
        .rd_data (cmd_raw),
        .full    (full),
        .empty   (mid_empty)
    );

    assign cmd_out = tslf_pkg::cmd_t'(cmd_raw);

    // back end may retire a command when the result queue has a free slot,
    // counting the slot freed by a pop in the same cycle
    assign out_space = !out_full || out_beat;

    tslf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd_out),
        .cmd_valid (!mid_empty),
        .out_space (out_space),
        .cmd_take  (cmd_take),
        .res       (res)
    );

    // result queue: the skid between back end and the consumer
    tslf_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_take),
        .wr_data (res),
        .rd_en   (out_beat),
        .rd_data (res_raw),
        .full    (out_full),
        .empty   (empty)
    );

    assign result = tslf_pkg::out_t'(res_raw);

    // a waiting result respects an ordered window on both axes
    a_x_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (cfg_reg.window_left <= cfg_reg.window_right)) |->
        ((result.pos_x >= cfg_reg.window_left) && (result.pos_x <= cfg_reg.window_right)))
        else $error("x result outside window");

    a_y_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (cfg_reg.window_top <= cfg_reg.window_bottom)) |->
        ((result.pos_y >= cfg_reg.window_top) && (result.pos_y <= cfg_reg.window_bottom)))
        else $error("y result outside window");

    a_back_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> (!mid_empty && out_space))
        else $error("back end retired without a command or room");

endmodule

@@ dv/two_axis_slew_limited_follower_tb.sv @@
module two_axis_slew_limited_follower_tb;

    localparam int POS_W = tslf_pkg::POS_W;
    localparam int SPEED_W = tslf_pkg::SPEED_W;
    localparam int LAG_W = tslf_pkg::LAG_W;
    localparam int TSTEP_W = tslf_pkg::TSTEP_W;
    localparam int FRAC_W = tslf_pkg::FRAC_W;
    localparam int CFG_INDEX_W = tslf_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W = tslf_pkg::CFG_DATA_W;

    // run limits and timing knobs
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;     // long receiver hold-off, fills the block
    localparam int SETTLE_CYCLES = 6;    // leave some slack after the last expected result
    localparam int MAX_SHOWN = 60;       // cap on printed mismatch lines
    localparam int PHASE_BEATS = 180;

    // predictor and store of expected positions
    class position_predictor;
        tslf_pkg::cfg_t regs;
        logic signed [POS_W-1:0] cam_x;
        logic signed [POS_W-1:0] cam_y;
        tslf_pkg::out_t expected_pos_q[$];
        int errors;
        int checked;
        int shown;

        function new();
            regs.speed_x = '0;
            regs.speed_y = '0;
            regs.max_lag_x = '0;
            regs.max_lag_y = '0;
            regs.window_left = tslf_pkg::POS_MIN;
            regs.window_top = tslf_pkg::POS_MIN;
            regs.window_right = tslf_pkg::POS_MAX;
            regs.window_bottom = tslf_pkg::POS_MAX;
            cam_x = '0;
            cam_y = '0;
            errors = 0;
            checked = 0;
            shown = 0;
        endfunction

        function void set_reg(tslf_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                tslf_pkg::REG_SPEED_X:       regs.speed_x = data[SPEED_W-1:0];
                tslf_pkg::REG_SPEED_Y:       regs.speed_y = data[SPEED_W-1:0];
                tslf_pkg::REG_MAX_LAG_X:     regs.max_lag_x = data[LAG_W-1:0];
                tslf_pkg::REG_MAX_LAG_Y:     regs.max_lag_y = data[LAG_W-1:0];
                tslf_pkg::REG_WINDOW_LEFT:   regs.window_left = data;
                tslf_pkg::REG_WINDOW_TOP:    regs.window_top = data;
                tslf_pkg::REG_WINDOW_RIGHT:  regs.window_right = data;
                tslf_pkg::REG_WINDOW_BOTTOM: regs.window_bottom = data;
                default: ;
            endcase
        endfunction

        function longint saturate(longint v);
            if (v < longint'(tslf_pkg::POS_MIN))
                return longint'(tslf_pkg::POS_MIN);
            if (v > longint'(tslf_pkg::POS_MAX))
                return longint'(tslf_pkg::POS_MAX);
            return v;
        endfunction

        // one axis of the follow rule, all in wide signed arithmetic
        function longint follow(longint pos, longint pt, longint speed, longint lag,
                                longint tstep);
            longint gap;
            longint stride;
            if (speed == 0)
                return pt;
            gap = (pos < pt) ? pt - pos : pos - pt;
            if (lag != 0 && gap > lag)
                return (pos < pt) ? saturate(pt - lag) : saturate(pt + lag);
            stride = (speed * tstep) >> FRAC_W;
            if (pos == pt)
                return pos;
            if (stride >= gap)
                return pt;
            return (pos < pt) ? pos + stride : pos - stride;
        endfunction

        // low edge first, high edge second, so an inverted window lands on the high edge
        function longint clamp(longint pos, longint lo, longint hi);
            if (pos < lo)
                pos = lo;
            if (pos > hi)
                pos = hi;
            return pos;
        endfunction

        function void take_input(tslf_pkg::in_t beat);
            longint nx;
            longint ny;
            tslf_pkg::out_t want;
            nx = longint'(cam_x);
            ny = longint'(cam_y);
            if (beat.has_target)
            begin
                nx = follow(nx, longint'(beat.follow_x), longint'(regs.speed_x),
                            longint'(regs.max_lag_x), longint'(beat.time_step));
                ny = follow(ny, longint'(beat.follow_y), longint'(regs.speed_y),
                            longint'(regs.max_lag_y), longint'(beat.time_step));
            end
            nx = clamp(nx, longint'(regs.window_left), longint'(regs.window_right));
            ny = clamp(ny, longint'(regs.window_top), longint'(regs.window_bottom));
            cam_x = nx[POS_W-1:0];
            cam_y = ny[POS_W-1:0];
            want.pos_x = cam_x;
            want.pos_y = cam_y;
            expected_pos_q.push_back(want);
        endfunction

        function void note_error();
            errors++;
            shown++;
            if (shown == MAX_SHOWN)
                $display("%0t further mismatch lines suppressed", $time);
        endfunction

        function void check_position(tslf_pkg::out_t got);
            tslf_pkg::out_t want;
            checked++;
            if (expected_pos_q.size() == 0)
            begin
                if (shown < MAX_SHOWN)
                    $display("%0t unexpected result beat: expected none, actual x=%0d y=%0d",
                             $time, got.pos_x, got.pos_y);
                note_error();
                return;
            end
            want = expected_pos_q.pop_front();
            if (got.pos_x !== want.pos_x)
            begin
                if (shown < MAX_SHOWN)
                    $display("%0t pos_x mismatch: expected %0d, actual %0d",
                             $time, want.pos_x, got.pos_x);
                note_error();
            end
            if (got.pos_y !== want.pos_y)
            begin
                if (shown < MAX_SHOWN)
                    $display("%0t pos_y mismatch: expected %0d, actual %0d",
                             $time, want.pos_y, got.pos_y);
                note_error();
            end
        endfunction

        function int pending();
            return expected_pos_q.size();
        endfunction
    endclass

    // dut connections, every input known from time zero
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    tslf_pkg::in_t item = '0;
    logic empty;
    logic pop = 1'b0;
    tslf_pkg::out_t result;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    position_predictor pred = new();

    // stimulus bookkeeping
    int src_idle_pct = 16;
    int sink_idle_pct = 16;
    bit hold_req = 1'b0;
    int beats_in = 0;
    int reg_writes = 0;
    int settings_used = 0;
    int unsigned cycles = 0;
    logic signed [POS_W-1:0] last_x = '0;
    logic signed [POS_W-1:0] last_y = '0;
    tslf_pkg::cfg_t cfg;

    two_axis_slew_limited_follower u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 time unit clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // watchdog: a stuck handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d positions still expected",
                     cycles, pred.pending());
            $display("FAIL");
            $finish;
        end
    end

    // sample both handshakes at the edge, before the dut's own updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                pred.take_input(item);
                beats_in++;
            end
            if (pop && !empty)
                pred.check_position(result);
        end
    end

    // receiver: random pop, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // offer one beat, with random gaps in front, and wait until it is taken
    task automatic send_beat(input tslf_pkg::in_t beat);
        while ($urandom_range(99) < src_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= beat;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // stop offering and let every expected position come back
    task automatic drain();
        push <= 1'b0;
        while (pred.pending() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic poke_reg(input tslf_pkg::cfg_idx_t idx,
                            input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        pred.set_reg(idx, data);
        reg_writes++;
    endtask

    // all eight registers; junk in the unused high bits of speeds and lags
    task automatic load_regs(input tslf_pkg::cfg_t c);
        poke_reg(tslf_pkg::REG_SPEED_X, {8'($urandom), c.speed_x});
        poke_reg(tslf_pkg::REG_SPEED_Y, {8'($urandom), c.speed_y});
        poke_reg(tslf_pkg::REG_MAX_LAG_X, {1'($urandom), c.max_lag_x});
        poke_reg(tslf_pkg::REG_MAX_LAG_Y, {1'($urandom), c.max_lag_y});
        poke_reg(tslf_pkg::REG_WINDOW_LEFT, c.window_left);
        poke_reg(tslf_pkg::REG_WINDOW_TOP, c.window_top);
        poke_reg(tslf_pkg::REG_WINDOW_RIGHT, c.window_right);
        poke_reg(tslf_pkg::REG_WINDOW_BOTTOM, c.window_bottom);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic tslf_pkg::cfg_t reset_cfg();
        tslf_pkg::cfg_t c;
        c.speed_x = '0;
        c.speed_y = '0;
        c.max_lag_x = '0;
        c.max_lag_y = '0;
        c.window_left = tslf_pkg::POS_MIN;
        c.window_top = tslf_pkg::POS_MIN;
        c.window_right = tslf_pkg::POS_MAX;
        c.window_bottom = tslf_pkg::POS_MAX;
        return c;
    endfunction

    function automatic tslf_pkg::in_t mk_beat(input logic ht,
                                              input logic signed [POS_W-1:0] px,
                                              input logic signed [POS_W-1:0] py,
                                              input logic [TSTEP_W-1:0] ts);
        tslf_pkg::in_t b;
        b.has_target = ht;
        b.follow_x = px;
        b.follow_y = py;
        b.time_step = ts;
        return b;
    endfunction

    function automatic logic [SPEED_W-1:0] pick_speed();
        case ($urandom_range(5))
            0: return '0;
            1: return SPEED_W'(1);
            2: return '1;
            3, 4: return SPEED_W'($urandom_range(16, 2048));
            default: return SPEED_W'($urandom);
        endcase
    endfunction

    function automatic logic [LAG_W-1:0] pick_lag();
        case ($urandom_range(5))
            0, 1: return '0;
            2: return LAG_W'(1);
            3: return '1;
            4: return LAG_W'($urandom_range(1, 1 << 14));
            default: return LAG_W'($urandom);
        endcase
    endfunction

    // returns {low edge, high edge}
    function automatic logic [2*POS_W-1:0] pick_window();
        logic signed [POS_W-1:0] lo;
        logic signed [POS_W-1:0] hi;
        case ($urandom_range(5))
            0, 1:
            begin
                lo = tslf_pkg::POS_MIN;
                hi = tslf_pkg::POS_MAX;
            end
            2:
            begin
                lo = $urandom_range(0, 1 << 20);
                lo = -lo;
                hi = $urandom_range(0, 1 << 20);
            end
            3:
            begin
                // inverted window
                lo = $urandom_range(1, 1 << 16);
                hi = lo - POS_W'($urandom_range(1, 1 << 12));
            end
            4:
            begin
                lo = $urandom;
                hi = $urandom;
            end
            default:
            begin
                lo = $urandom_range(1) ? tslf_pkg::POS_MAX : tslf_pkg::POS_MIN;
                hi = lo;
            end
        endcase
        return {lo, hi};
    endfunction

    function automatic tslf_pkg::cfg_t pick_cfg();
        tslf_pkg::cfg_t c;
        logic [2*POS_W-1:0] w;
        c.speed_x = pick_speed();
        c.speed_y = pick_speed();
        c.max_lag_x = pick_lag();
        c.max_lag_y = pick_lag();
        w = pick_window();
        c.window_left = w[2*POS_W-1:POS_W];
        c.window_right = w[POS_W-1:0];
        w = pick_window();
        c.window_top = w[2*POS_W-1:POS_W];
        c.window_bottom = w[POS_W-1:0];
        return c;
    endfunction

    // mostly a short walk from the last point, so the position trails and catches up
    function automatic logic signed [POS_W-1:0] pick_point(input logic signed [POS_W-1:0] prev);
        logic signed [POS_W-1:0] d;
        d = $urandom_range(0, 1 << 12);
        case ($urandom_range(9))
            0: return tslf_pkg::POS_MIN;
            1: return tslf_pkg::POS_MAX;
            2: return '0;
            3: return $urandom;
            4: return prev;
            default: return $urandom_range(1) ? prev + d : prev - d;
        endcase
    endfunction

    function automatic logic [TSTEP_W-1:0] pick_tstep();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return TSTEP_W'($urandom);
            default: return TSTEP_W'($urandom_range(0, 1024));
        endcase
    endfunction

    task automatic run_random(input int count, input int hold_at, input int pause_at);
        tslf_pkg::in_t b;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == pause_at)
                drain();
            b.has_target = ($urandom_range(99) < 85);
            b.follow_x = pick_point(last_x);
            b.follow_y = pick_point(last_y);
            b.time_step = pick_tstep();
            last_x = b.follow_x;
            last_y = b.follow_y;
            send_beat(b);
        end
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero speed snaps, full window
        send_beat(mk_beat(1'b1, tslf_pkg::POS_MAX, tslf_pkg::POS_MIN, '0));
        send_beat(mk_beat(1'b1, tslf_pkg::POS_MIN, tslf_pkg::POS_MAX, '1));
        send_beat(mk_beat(1'b0, '0, '0, 16'h1234));
        send_beat(mk_beat(1'b1, '0, '0, '0));
        drain();

        // fastest x, slowest y: full step reaches the point, small step does not
        cfg = reset_cfg();
        cfg.speed_x = '1;
        cfg.speed_y = SPEED_W'(1);
        load_regs(cfg);
        send_beat(mk_beat(1'b1, tslf_pkg::POS_MAX, tslf_pkg::POS_MAX, '1));
        send_beat(mk_beat(1'b1, tslf_pkg::POS_MAX, tslf_pkg::POS_MAX, '0));
        send_beat(mk_beat(1'b1, tslf_pkg::POS_MIN, 32'sd511, 16'h0100));
        send_beat(mk_beat(1'b1, tslf_pkg::POS_MIN, 32'sd256, 16'h0100));
        send_beat(mk_beat(1'b0, tslf_pkg::POS_MAX, tslf_pkg::POS_MIN, '1));
        drain();

        // lag limits: largest on x, smallest on y, including distance equal to the limit
        cfg = reset_cfg();
        cfg.speed_x = SPEED_W'(1);
        cfg.speed_y = SPEED_W'(256);
        cfg.max_lag_x = '1;
        cfg.max_lag_y = LAG_W'(1);
        load_regs(cfg);
        send_beat(mk_beat(1'b1, tslf_pkg::POS_MIN, 32'sd1000, 16'h0100));
        send_beat(mk_beat(1'b1, -32'sd1, 32'sd999, 16'h0100));
        send_beat(mk_beat(1'b1, tslf_pkg::POS_MAX, 32'sd1000, 16'h0100));
        send_beat(mk_beat(1'b1, tslf_pkg::POS_MAX, 32'sd1000, '1));
        drain();

        // inverted x window, narrow y window
        cfg = reset_cfg();
        cfg.window_left = 32'sd100;
        cfg.window_right = -32'sd100;
        cfg.window_top = -32'sd50;
        cfg.window_bottom = 32'sd50;
        load_regs(cfg);
        send_beat(mk_beat(1'b0, '0, '0, '0));
        send_beat(mk_beat(1'b1, tslf_pkg::POS_MIN, tslf_pkg::POS_MIN, '0));
        send_beat(mk_beat(1'b1, tslf_pkg::POS_MAX, tslf_pkg::POS_MAX, '1));
        drain();

        // window pinned at the range ends
        cfg = reset_cfg();
        cfg.window_left = tslf_pkg::POS_MAX;
        cfg.window_top = tslf_pkg::POS_MIN;
        cfg.window_bottom = tslf_pkg::POS_MIN;
        load_regs(cfg);
        send_beat(mk_beat(1'b1, '0, '0, '0));
        drain();

        // random phases, each under its own setting
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:
                begin
                    cfg = reset_cfg();
                    cfg.speed_x = '1;
                    cfg.speed_y = '1;
                    cfg.max_lag_x = '1;
                    cfg.max_lag_y = '1;
                end
                1:
                begin
                    cfg.speed_x = SPEED_W'(1);
                    cfg.speed_y = SPEED_W'(1);
                    cfg.max_lag_x = LAG_W'(1);
                    cfg.max_lag_y = LAG_W'(1);
                    cfg.window_left = -32'sd256;
                    cfg.window_top = -32'sd256;
                    cfg.window_right = 32'sd256;
                    cfg.window_bottom = 32'sd256;
                end
                default: cfg = pick_cfg();
            endcase
            load_regs(cfg);
            // one phase runs back to back with no gaps on either side
            src_idle_pct = (p == 2) ? 0 : 16;
            sink_idle_pct = (p == 2) ? 0 : 16;
            run_random(PHASE_BEATS, (p == 3) ? 40 : -1, (p == 4) ? 90 : -1);
        end

        drain();
        $display("covered %0d input beats and %0d result beats under %0d register settings",
                 beats_in, pred.checked, settings_used);
        $display("(%0d register writes, %0d mismatches)", reg_writes, pred.errors);
        if (pred.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
